### design/lru_key_value_cache_defines.svh
// ----------------------------------------------------------------------------
// lru key-value cache assertion macros
// property wrappers on the block clock with reset masking
// ----------------------------------------------------------------------------
`ifndef LRU_KEY_VALUE_CACHE_DEFINES_SVH
`define LRU_KEY_VALUE_CACHE_DEFINES_SVH

// same-cycle implication
`define LKVC_ASSERT_IMP(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("lkvc assertion failed");

// next-cycle implication
`define LKVC_ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("lkvc assertion failed");

`endif

### design/lkvc_pkg.sv
// ----------------------------------------------------------------------------
// lkvc_pkg
// types and constants shared by the lru key-value cache
// ----------------------------------------------------------------------------
package lkvc_pkg;

    localparam int unsigned DEFAULT_MAX_ENTRIES = 16;
    localparam int unsigned KEY_W               = 32;
    localparam int unsigned VAL_W               = 32;
    localparam int unsigned CAP_REG_W           = 5;
    localparam logic [CAP_REG_W-1:0] CAP_RESET  = 5'd16;

    typedef enum logic {
        OP_GET = 1'b0,
        OP_PUT = 1'b1
    } t_opcode;

    typedef enum logic {
        ST_IDLE   = 1'b0,
        ST_UPDATE = 1'b1
    } t_state;

    typedef struct packed {
        t_opcode                   opcode;
        logic [KEY_W-1:0]          key;
        logic signed [VAL_W-1:0]   write_value;
    } t_cmd;

    typedef struct packed {
        logic                      found;
        logic signed [VAL_W-1:0]   read_value;
        logic                      evicted;
    } t_result;

    typedef struct packed {
        logic                      valid;
        logic [KEY_W-1:0]          key;
        logic [VAL_W-1:0]          value;
    } t_entry;

    typedef struct packed {
        logic                      lookup;
        logic                      update;
        logic                      put_new;
        logic                      found;
    } t_cell_ctrl;

endpackage

### design/lkvc_cell.sv
// ----------------------------------------------------------------------------
// lkvc_cell
// one recency slot: holds an entry, matches the key, shifts from its neighbour
// ----------------------------------------------------------------------------
module lkvc_cell import lkvc_pkg::*; #(
    parameter int unsigned IDX   = 0,
    parameter int unsigned CAP_W = 5
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  t_cell_ctrl         i_ctrl,
    input  logic [KEY_W-1:0]   i_key,
    input  logic [CAP_W-1:0]   i_cap,
    input  t_entry             i_prev,
    input  logic               i_hit_tail,
    output logic               o_hit_tail,
    input  logic [VAL_W-1:0]   i_hit_val,
    output logic [VAL_W-1:0]   o_hit_val,
    output t_entry             o_entry,
    output logic               o_match
);

    logic               r_valid;
    logic [KEY_W-1:0]   r_key;
    logic [VAL_W-1:0]   r_value;
    logic               r_match;
    logic               n_match;
    logic               n_take;
    logic               n_valid;

    always_comb begin
        n_match = r_valid && (r_key == i_key);
        n_take  = i_ctrl.update && (i_ctrl.put_new || (i_ctrl.found && o_hit_tail));
        n_valid = i_prev.valid && (!i_ctrl.put_new || (CAP_W'(IDX) < i_cap));
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
            r_match <= 1'b0;
        end else begin
            if (i_ctrl.lookup) begin
                r_match <= n_match;
            end
            if (n_take) begin
                r_valid <= n_valid;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (n_take) begin
            r_key   <= i_prev.key;
            r_value <= i_prev.value;
        end
    end

    assign o_hit_tail    = r_match | i_hit_tail;
    assign o_hit_val     = i_hit_val | (r_match ? r_value : '0);
    assign o_entry.valid = r_valid;
    assign o_entry.key   = r_key;
    assign o_entry.value = r_value;
    assign o_match       = r_match;

endmodule

### design/lru_key_value_cache.sv
// ----------------------------------------------------------------------------
// lru_key_value_cache
// fully associative key-value store with least-recently-used replacement
// ----------------------------------------------------------------------------
// channel   direction  handshake                     payload
// command   in         start high, busy low          i_cmd (t_cmd)
// result    out        o_result_strobe, one cycle    o_result (t_result)
// config    in         i_cfg_valid and o_cfg_ready   i_cfg_data (capacity)
//
// each beat has an accept cycle and an update cycle: the accept cycle compares the key in every cell,
// the update cycle shifts the cell row to put the touched key at the head.
// the result shows in the cycle after the update, when busy is low again.
// synchronous reset empties the row at once; no clearing pass.
// results cannot be stalled; config is always ready.
// ----------------------------------------------------------------------------
`include "lru_key_value_cache_defines.svh"

module lru_key_value_cache import lkvc_pkg::*; #(
    parameter int unsigned MAX_ENTRIES = DEFAULT_MAX_ENTRIES
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  start,
    output logic                  busy,
    input  t_cmd                  i_cmd,
    output logic                  o_result_strobe,
    output t_result               o_result,
    input  logic                  i_cfg_valid,
    output logic                  o_cfg_ready,
    input  logic [CAP_REG_W-1:0]  i_cfg_data
);

    localparam int unsigned CAP_W = $clog2(MAX_ENTRIES + 1);
    localparam int unsigned IDX_W = (MAX_ENTRIES > 1) ? $clog2(MAX_ENTRIES) : 1;

    t_state                 r_state;
    t_state                 n_state;
    t_cmd                   r_cmd;
    t_result                r_result;
    t_result                n_result;
    logic                   r_strobe;
    logic [CAP_REG_W-1:0]   r_capacity;
    logic [CAP_W-1:0]       w_cap;
    logic                   w_accept;
    logic                   w_update;
    t_cell_ctrl             w_ctrl;
    t_entry                 w_head;
    t_entry                 w_entry [MAX_ENTRIES];
    logic [MAX_ENTRIES-1:0] w_valid_vec;
    logic [MAX_ENTRIES-1:0] w_match_vec;
    logic                   w_hit_tail [MAX_ENTRIES+1];
    logic [VAL_W-1:0]       w_hit_val  [MAX_ENTRIES+1];
    logic                   w_found;
    logic                   w_is_put;

    // fsm next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            ST_IDLE:   if (start) n_state = ST_UPDATE;
            ST_UPDATE: n_state = ST_IDLE;
            default:   n_state = ST_IDLE;
        endcase
    end

    // fsm outputs
    always_comb begin
        busy     = 1'b0;
        w_update = 1'b0;
        case (r_state)
            ST_IDLE: begin
                busy     = 1'b0;
                w_update = 1'b0;
            end
            ST_UPDATE: begin
                busy     = 1'b1;
                w_update = 1'b1;
            end
            default: begin
                busy     = 1'b0;
                w_update = 1'b0;
            end
        endcase
    end

    assign w_accept    = start && !busy;
    assign o_cfg_ready = 1'b1;

    // effective capacity
    always_comb begin
        if (r_capacity == '0) begin
            w_cap = CAP_W'(1);
        end else if (32'(r_capacity) > MAX_ENTRIES) begin
            w_cap = CAP_W'(MAX_ENTRIES);
        end else begin
            w_cap = CAP_W'(r_capacity);
        end
    end

    assign w_found  = w_hit_tail[0];
    assign w_is_put = (r_cmd.opcode == OP_PUT);

    always_comb begin
        w_ctrl.lookup  = w_accept;
        w_ctrl.update  = w_update;
        w_ctrl.put_new = w_is_put && !w_found;
        w_ctrl.found   = w_found;
        w_head.valid   = 1'b1;
        w_head.key     = r_cmd.key;
        w_head.value   = w_is_put ? r_cmd.write_value : w_hit_val[MAX_ENTRIES];
    end

    assign w_hit_tail[MAX_ENTRIES] = 1'b0;
    assign w_hit_val[0]            = '0;

    for (genvar gi = 0; gi < MAX_ENTRIES; gi++) begin : g_cell
        lkvc_cell #(
            .IDX   (gi),
            .CAP_W (CAP_W)
        ) u_cell (
            .i_clk      (i_clk),
            .i_rst_n    (i_rst_n),
            .i_ctrl     (w_ctrl),
            .i_key      (i_cmd.key),
            .i_cap      (w_cap),
            .i_prev     ((gi == 0) ? w_head : w_entry[(gi == 0) ? 0 : gi - 1]),
            .i_hit_tail (w_hit_tail[gi+1]),
            .o_hit_tail (w_hit_tail[gi]),
            .i_hit_val  (w_hit_val[gi]),
            .o_hit_val  (w_hit_val[gi+1]),
            .o_entry    (w_entry[gi]),
            .o_match    (w_match_vec[gi])
        );
        assign w_valid_vec[gi] = w_entry[gi].valid;
    end

    always_comb begin
        n_result.found      = w_found;
        n_result.read_value = (!w_is_put && w_found) ? w_hit_val[MAX_ENTRIES] : '0;
        n_result.evicted    = w_is_put && !w_found
                              && w_valid_vec[IDX_W'(w_cap - 1'b1)];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= ST_IDLE;
            r_strobe   <= 1'b0;
            r_capacity <= CAP_RESET;
        end else begin
            r_state  <= n_state;
            r_strobe <= w_update;
            if (i_cfg_valid && o_cfg_ready) begin
                r_capacity <= i_cfg_data;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_cmd <= i_cmd;
        end
        if (w_update) begin
            r_result <= n_result;
        end
    end

    assign o_result_strobe = r_strobe;
    assign o_result        = r_result;

    `LKVC_ASSERT_NEXT(a_accept_busy, w_accept, busy && !o_result_strobe)
    `LKVC_ASSERT_NEXT(a_update_strobe, w_update, o_result_strobe && !busy)
    `LKVC_ASSERT_IMP(a_valid_prefix, 1'b1, ((w_valid_vec + 1'b1) & w_valid_vec) == '0)
    `LKVC_ASSERT_IMP(a_single_hit, w_update, $onehot0(w_match_vec))

endmodule

### verif/lru_key_value_cache_checker.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// lru_key_value_cache_checker
// watches the command, config and result channels of the lru cache, keeps
// its own slot-level copy of the store with recency ranks, predicts one
// result per accepted command and compares each result beat in order
// ----------------------------------------------------------------------------
module lru_key_value_cache_checker import lkvc_pkg::*; #(
    parameter int unsigned SLOTS = DEFAULT_MAX_ENTRIES
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_start,
    input  logic                  i_busy,
    input  t_cmd                  i_cmd,
    input  logic                  i_result_strobe,
    input  t_result               i_result,
    input  logic                  i_cfg_valid,
    input  logic                  i_cfg_ready,
    input  logic [CAP_REG_W-1:0]  i_cfg_data,
    output int                    o_fail_count,
    output int                    o_awaited
);

    bit                        slot_used [SLOTS];
    logic [KEY_W-1:0]          slot_key  [SLOTS];
    logic signed [VAL_W-1:0]   slot_val  [SLOTS];
    int unsigned               slot_age  [SLOTS];
    int unsigned               used_count;
    logic [CAP_REG_W-1:0]      capacity_reg;
    t_result                   awaited_results [$];

    function automatic int unsigned capacity_limit();
        int unsigned c;
        c = capacity_reg;
        if (c == 0) c = 1;
        if (c > SLOTS) c = SLOTS;
        return c;
    endfunction

    // slot s becomes most recent, younger entries age by one
    function automatic void promote(int unsigned s);
        int unsigned r;
        r = slot_age[s];
        for (int unsigned i = 0; i < SLOTS; i++) begin
            if (slot_used[i] && slot_age[i] < r) slot_age[i]++;
        end
        slot_age[s] = 0;
    endfunction

    function automatic void drop_oldest();
        int unsigned victim;
        int unsigned oldest;
        bit          seen;
        victim = 0;
        oldest = 0;
        seen   = 1'b0;
        for (int unsigned i = 0; i < SLOTS; i++) begin
            if (slot_used[i] && (!seen || slot_age[i] > oldest)) begin
                oldest = slot_age[i];
                victim = i;
                seen   = 1'b1;
            end
        end
        if (seen) begin
            slot_used[victim] = 1'b0;
            if (used_count > 0) used_count--;
        end
    endfunction

    function automatic t_result cache_access(t_cmd c);
        t_result     r;
        int unsigned hit;
        int unsigned free_slot;
        int unsigned cap;
        bit          present;
        r         = '0;
        hit       = 0;
        present   = 1'b0;
        free_slot = SLOTS;
        for (int unsigned i = 0; i < SLOTS; i++) begin
            if (!present && slot_used[i] && slot_key[i] == c.key) begin
                present = 1'b1;
                hit     = i;
            end
        end
        r.found = present;
        if (c.opcode == OP_GET) begin
            if (present) begin
                r.read_value = slot_val[hit];
                promote(hit);
            end
        end else if (present) begin
            slot_val[hit] = c.write_value;
            promote(hit);
        end else begin
            cap = capacity_limit();
            while (used_count >= cap && used_count > 0) begin
                drop_oldest();
                r.evicted = 1'b1;
            end
            for (int unsigned i = 0; i < SLOTS; i++) begin
                if (free_slot == SLOTS && !slot_used[i]) free_slot = i;
            end
            if (free_slot < SLOTS) begin
                for (int unsigned j = 0; j < SLOTS; j++) begin
                    if (slot_used[j]) slot_age[j]++;
                end
                slot_used[free_slot] = 1'b1;
                slot_key[free_slot]  = c.key;
                slot_val[free_slot]  = c.write_value;
                slot_age[free_slot]  = 0;
                used_count++;
            end
        end
        return r;
    endfunction

    function automatic void compare_field(string name, logic [VAL_W-1:0] want,
                                          logic [VAL_W-1:0] got);
        if (got !== want) begin
            $display("%0t %s mismatch: expected %0h actual %0h", $time, name, want, got);
            o_fail_count++;
        end
    endfunction

    always @(posedge i_clk) begin : watch
        t_result want;
        if (!i_rst_n) begin
            for (int unsigned i = 0; i < SLOTS; i++) begin
                slot_used[i] = 1'b0;
                slot_key[i]  = '0;
                slot_val[i]  = '0;
                slot_age[i]  = 0;
            end
            used_count   = 0;
            capacity_reg = CAP_RESET;
            awaited_results.delete();
        end else begin
            if (i_result_strobe === 1'b1) begin
                if (awaited_results.size() == 0) begin
                    $display("%0t result beat with nothing awaited: expected none actual %0h",
                             $time, i_result);
                    o_fail_count++;
                end else begin
                    want = awaited_results.pop_front();
                    compare_field("found", want.found, i_result.found);
                    compare_field("read_value", want.read_value, i_result.read_value);
                    compare_field("evicted", want.evicted, i_result.evicted);
                end
            end else if (i_result_strobe !== 1'b0) begin
                $display("%0t result strobe unknown: expected 0 or 1 actual %b", $time,
                         i_result_strobe);
                o_fail_count++;
            end
            if (i_cfg_valid && i_cfg_ready === 1'b1) capacity_reg = i_cfg_data;
            if (i_start && i_busy === 1'b0) awaited_results.push_back(cache_access(i_cmd));
        end
        o_awaited = awaited_results.size();
    end

endmodule

### verif/lru_key_value_cache_tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// lru_key_value_cache_tb
// drives get and put commands into the lru cache in random bursts, over a
// series of capacity settings including the extremes; a short directed run
// covers key and value extremes, updates, ordered eviction and lowered
// capacity, then random traffic on small key pools keeps hits and evictions
// frequent; the checker beside the block predicts and compares every beat
// ----------------------------------------------------------------------------
module lru_key_value_cache_tb;
    import lkvc_pkg::*;

    localparam int CYCLE_LIMIT  = 200000;
    localparam int POOL_DEPTH   = 24;
    localparam int PHASE_ITEMS  = 50;

    logic                  i_clk        = 1'b0;
    logic                  i_rst_n      = 1'b0;
    logic                  start        = 1'b0;
    logic                  busy;
    t_cmd                  i_cmd        = '0;
    logic                  o_result_strobe;
    t_result               o_result;
    logic                  i_cfg_valid  = 1'b0;
    logic                  o_cfg_ready;
    logic [CAP_REG_W-1:0]  i_cfg_data   = '0;

    int                    fail_count;
    int                    awaited;
    int                    cycle_count  = 0;
    int                    burst_left   = 0;
    int                    pool_size    = POOL_DEPTH;
    logic [KEY_W-1:0]      key_pool [POOL_DEPTH];
    logic [CAP_REG_W-1:0]  phase_caps [10];

    always begin
        #1 i_clk = 1'b1;
        #1 i_clk = 1'b0;
    end

    lru_key_value_cache dut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .start           (start),
        .busy            (busy),
        .i_cmd           (i_cmd),
        .o_result_strobe (o_result_strobe),
        .o_result        (o_result),
        .i_cfg_valid     (i_cfg_valid),
        .o_cfg_ready     (o_cfg_ready),
        .i_cfg_data      (i_cfg_data)
    );

    lru_key_value_cache_checker checker_i (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_start         (start),
        .i_busy          (busy),
        .i_cmd           (i_cmd),
        .i_result_strobe (o_result_strobe),
        .i_result        (o_result),
        .i_cfg_valid     (i_cfg_valid),
        .i_cfg_ready     (o_cfg_ready),
        .i_cfg_data      (i_cfg_data),
        .o_fail_count    (fail_count),
        .o_awaited       (awaited)
    );

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("TB_ERROR");
            $finish;
        end
    end

    // lower start and hold it off for a span set by n, n at least one
    task automatic pause(int n);
        start <= 1'b0;
        repeat (n) @(posedge i_clk);
    endtask

    // one command beat, then the burst decides whether a gap follows
    task automatic issue(t_opcode op, logic [KEY_W-1:0] k, logic signed [VAL_W-1:0] v);
        bit taken;
        start <= 1'b1;
        i_cmd <= '{opcode: op, key: k, write_value: v};
        forever begin
            @(negedge i_clk);
            taken = (busy == 1'b0);
            @(posedge i_clk);
            if (taken) break;
        end
        if (burst_left == 0) begin
            pause($urandom_range(1, 5));
            burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(15, 30)
                                                     : $urandom_range(1, 6);
        end else begin
            burst_left--;
        end
    endtask

    task automatic wait_drained();
        pause($urandom_range(1, 3));
        forever begin
            @(negedge i_clk);
            if (awaited == 0) break;
        end
        @(posedge i_clk);
    endtask

    task automatic write_capacity(logic [CAP_REG_W-1:0] cap);
        bit taken;
        i_cfg_valid <= 1'b1;
        i_cfg_data  <= cap;
        forever begin
            @(negedge i_clk);
            taken = (o_cfg_ready == 1'b1);
            @(posedge i_clk);
            if (taken) break;
        end
        i_cfg_valid <= 1'b0;
        @(posedge i_clk);
    endtask

    function automatic logic [KEY_W-1:0] pick_key();
        if ($urandom_range(0, 9) < 8) return key_pool[$urandom_range(0, pool_size - 1)];
        return $urandom;
    endfunction

    function automatic logic signed [VAL_W-1:0] pick_value();
        case ($urandom_range(0, 9))
            0:       return 32'sh7fffffff;
            1:       return 32'sh80000000;
            2:       return -32'sd1;
            default: return $urandom;
        endcase
    endfunction

    initial begin
        phase_caps = '{5'd16, 5'd1, 5'd0, 5'd31, 5'd5, 5'd2, 5'd17, 5'd8, 5'd3, 5'd16};
        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // extremes, update in place and misses at reset capacity
        issue(OP_PUT, 32'h0000_0000, 32'sh7fffffff);
        issue(OP_PUT, 32'hffff_ffff, 32'sh80000000);
        issue(OP_GET, 32'h0000_0000, 32'sh5555_5555);
        issue(OP_GET, 32'hffff_ffff, 32'sh0);
        issue(OP_GET, 32'h0000_0005, 32'sh0);
        issue(OP_PUT, 32'h0000_0000, -32'sd1);
        issue(OP_GET, 32'h0000_0000, 32'sh0);

        // capacity lowered to just above the fill level, then eviction order
        wait_drained();
        write_capacity(5'd3);
        issue(OP_PUT, 32'haaaa_aaaa, 32'sh1111_1111);
        issue(OP_PUT, 32'h5555_5555, 32'sh2222_2222);
        issue(OP_PUT, 32'h0000_0003, 32'sh3333_3333);
        issue(OP_GET, 32'haaaa_aaaa, 32'sh0);
        issue(OP_PUT, 32'h0000_0004, 32'sh4444_4444);
        issue(OP_GET, 32'h5555_5555, 32'sh0);
        issue(OP_GET, 32'h0000_0003, 32'sh0);

        wait_drained();
        write_capacity(5'd1);
        issue(OP_PUT, 32'h1234_5678, 32'sh0);
        issue(OP_GET, 32'h1234_5678, 32'sh0);
        issue(OP_PUT, 32'h8765_4321, 32'sh7fffffff);

        // zero acts as one
        wait_drained();
        write_capacity(5'd0);
        issue(OP_PUT, 32'hdead_beef, 32'sh8000_0000);
        issue(OP_GET, 32'h8765_4321, 32'sh0);

        foreach (phase_caps[p]) begin
            wait_drained();
            write_capacity(phase_caps[p]);
            pool_size = $urandom_range(4, POOL_DEPTH);
            foreach (key_pool[i]) key_pool[i] = $urandom;
            key_pool[0] = 32'h0000_0000;
            key_pool[1] = 32'hffff_ffff;
            repeat (PHASE_ITEMS) begin
                issue($urandom_range(0, 1) ? OP_PUT : OP_GET, pick_key(), pick_value());
            end
        end

        wait_drained();
        repeat (8) @(posedge i_clk);
        if (fail_count == 0) begin
            $display("TB_OK");
        end else begin
            $display("TB_ERROR");
        end
        $finish;
    end

endmodule

### filelist.f
+incdir+design
design/lkvc_pkg.sv
design/lkvc_cell.sv
design/lru_key_value_cache.sv
verif/lru_key_value_cache_checker.sv
verif/lru_key_value_cache_tb.sv
